// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/gpdt_pkg.sv =====
`default_nettype none

package gpdt_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 12;
  localparam int TICK_BITS  = 12;
  localparam int POS_W      = 12;
  localparam int STEP_W     = 13;
  localparam int LIM_W      = 12;
  localparam int LIM_MAX    = 2048;
  localparam int ALPHA_W    = 17;
  localparam int ALPHA_ONE  = 65536;

  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 25;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int FILT_W     = 32;
  localparam int SUM_W      = 56;
  localparam int TICK_SHIFT = ANGLE_BITS + 20 - TICK_BITS;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_W       = 56;
  localparam int OUT_W      = 56;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LPF_ALPHA        = 3'd0,
    CFG_HPF_ALPHA        = 3'd1,
    CFG_PROP_GAIN        = 3'd2,
    CFG_RATE_GAIN        = 3'd3,
    CFG_PITCH_STEP_LIMIT = 3'd4,
    CFG_YAW_STEP_LIMIT   = 3'd5,
    CFG_SLOW_YAW_FOLLOW  = 3'd6
  } cfg_index_t;

endpackage

`default_nettype wire

// ===== rtl/gpdt_mul.sv =====
`default_nettype none

module gpdt_mul (
  input  logic                                  clk,
  input  logic signed [gpdt_pkg::MUL_A_W-1:0]   a,
  input  logic signed [gpdt_pkg::MUL_B_W-1:0]   b,
  output logic signed [gpdt_pkg::PROD_W-1:0]    prod
);
  import gpdt_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

// ===== rtl/gimbal_pd_tick_controller.sv =====
// Gimbal PD tick controller.
// Input stream: one beat per control tick carrying the measured pitch and
// yaw binary angles and the present servo positions. Output stream: one
// beat per input beat with the new pitch and yaw goals, the steps applied
// and a calibrating flag in tuser.
// The first beat after reset latches the reference angles, clears the
// filters and returns the present positions with zero steps. Every later
// beat runs through one shared 32x25 multiplier under a sequencer: a
// multiply and an update step per filter (the yaw high-pass tracker only
// when it is on), then the pitch and yaw command sums and their tick
// conversions. Either result is loaded into the output register from the
// last sequencer step; no new beat is taken until the previous one has
// passed through the sequencer.
// s_axis_tready is high only while the sequencer is idle; the next beat is
// taken while the previous result still waits in the output register.
// If the receiver stalls, the finished result waits in the last sequencer
// step until the output register frees. cfg_ready is always high; write
// the registers only while the block is idle. Reset (rst, synchronous)
// restores the register defaults, clears the filters and arms calibration.
`default_nettype none
`include "assert_macros.svh"

module gimbal_pd_tick_controller (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gpdt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gpdt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // pitch_angle, yaw_angle, pitch_position, yaw_position
  input  logic [gpdt_pkg::IN_W-1:0]          s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // goal_pitch, goal_yaw, step_pitch, step_yaw, zero pad
  output logic [gpdt_pkg::OUT_W-1:0]         m_axis_tdata,
  // calibrating
  output logic                               m_axis_tuser
);
  import gpdt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_TRK_M, S_TRK_W, S_PF_M, S_PF_W, S_YF_M, S_YF_W,
    S_PP_M, S_PR_M, S_PR_W, S_PT, S_YR_M, S_YR_W, S_YT, S_DONE
  } state_t;

  state_t state;

  logic [ALPHA_W-1:0]    lpf_alpha, hpf_alpha;
  logic [15:0]           prop_gain;
  logic [23:0]           rate_gain;
  logic [LIM_W-1:0]      pitch_step_limit, yaw_step_limit;
  logic                  slow_yaw_follow;

  logic                  calibrated;
  logic [ANGLE_BITS-1:0] ref_p, ref_y, prev_p, prev_y;
  logic signed [FILT_W-1:0] pf, yf, trk;

  logic [ANGLE_BITS-1:0] pa, ya;
  logic [POS_W-1:0]      ppos, ypos;
  logic signed [SUM_W-1:0] acc;
  logic signed [STEP_W-1:0] step_p, step_y;
  logic                  cal;

  logic                  out_valid;
  logic [POS_W-1:0]      out_goal_p, out_goal_y;
  logic signed [STEP_W-1:0] out_step_p, out_step_y;
  logic                  out_cal;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic [ANGLE_BITS:0]   d_pitch, prate;
  logic [ANGLE_BITS-1:0] w_yaw, yrate;
  logic signed [FILT_W-1:0] perr, yerr, yerr_hp, yerr_x;
  logic [FILT_W:0]       trk_diff, pf_diff, yf_diff;
  logic [ALPHA_W-1:0]    lpf_c, hpf_c;
  logic [LIM_W-1:0]      lim_p_c, lim_y_c;
  logic signed [POS_W+1:0] gp_sum;
  logic [POS_W-1:0]      goal_p, goal_y;
  logic [STEP_W-1:0]     out_mag_p, out_mag_y;
  logic                  steps_in_limit;
  logic                  load_out;

  localparam logic [SUM_W-1:0] TICK_HALF = SUM_W'(1) << (TICK_SHIFT - 1);

  function automatic logic [ALPHA_W-1:0] alpha_of(input logic [ALPHA_W-1:0] a);
    return (a > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : a;
  endfunction

  function automatic logic [LIM_W-1:0] lim_of(input logic [LIM_W-1:0] l);
    if (l == '0) return LIM_W'(1);
    if (l > LIM_W'(LIM_MAX)) return LIM_W'(LIM_MAX);
    return l;
  endfunction

  function automatic logic signed [FILT_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] t;
    t = p + PROD_W'(32768);
    return t[FILT_W+15:16];
  endfunction

  function automatic logic signed [STEP_W-1:0] tick_step(
    input logic signed [SUM_W-1:0] s,
    input logic [LIM_W-1:0] lim
  );
    logic [SUM_W-1:0] r;
    logic [SUM_W-TICK_SHIFT-1:0] t;
    logic [LIM_W-1:0] mag;
    r = s[SUM_W-1] ? (~s + TICK_HALF + SUM_W'(1)) : (s + TICK_HALF);
    t = r[SUM_W-1:TICK_SHIFT];
    mag = (t > {{(SUM_W-TICK_SHIFT-LIM_W){1'b0}}, lim}) ? lim : t[LIM_W-1:0];
    if (!s[SUM_W-1] && s != '0) return -$signed({1'b0, mag});
    return $signed({1'b0, mag});
  endfunction

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_W - 2*POS_W - 2*STEP_W){1'b0}},
                          out_step_y, out_step_p, out_goal_y, out_goal_p};
  assign m_axis_tuser  = out_cal;

  assign lpf_c   = alpha_of(lpf_alpha);
  assign hpf_c   = alpha_of(hpf_alpha);
  assign lim_p_c = lim_of(pitch_step_limit);
  assign lim_y_c = lim_of(yaw_step_limit);

  assign d_pitch = {pa[ANGLE_BITS-1], pa} - {ref_p[ANGLE_BITS-1], ref_p};
  assign w_yaw   = ya - ref_y;
  assign prate   = {pa[ANGLE_BITS-1], pa} - {prev_p[ANGLE_BITS-1], prev_p};
  assign yrate   = ya - prev_y;
  assign perr    = {{(FILT_W-ANGLE_BITS-1-FRAC_BITS){d_pitch[ANGLE_BITS]}},
                    d_pitch, {FRAC_BITS{1'b0}}};
  assign yerr    = {{(FILT_W-ANGLE_BITS-FRAC_BITS){w_yaw[ANGLE_BITS-1]}},
                    w_yaw, {FRAC_BITS{1'b0}}};
  assign yerr_hp = yerr - trk;
  assign yerr_x  = slow_yaw_follow ? yerr_hp : yerr;

  assign trk_diff = {yerr[FILT_W-1], yerr} - {trk[FILT_W-1], trk};
  assign pf_diff  = {perr[FILT_W-1], perr} - {pf[FILT_W-1], pf};
  assign yf_diff  = {yerr_x[FILT_W-1], yerr_x} - {yf[FILT_W-1], yf};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_TRK_M: begin
        mul_a = trk_diff[MUL_A_W-1:0];
        mul_b = {{(MUL_B_W-ALPHA_W){1'b0}}, hpf_c};
      end
      S_PF_M: begin
        mul_a = pf_diff[MUL_A_W-1:0];
        mul_b = {{(MUL_B_W-ALPHA_W){1'b0}}, lpf_c};
      end
      S_YF_M: begin
        mul_a = yf_diff[MUL_A_W-1:0];
        mul_b = {{(MUL_B_W-ALPHA_W){1'b0}}, lpf_c};
      end
      S_PP_M: begin
        mul_a = pf;
        mul_b = {{(MUL_B_W-16){1'b0}}, prop_gain};
      end
      S_PR_M: begin
        mul_a = {{(MUL_A_W-ANGLE_BITS-1){prate[ANGLE_BITS]}}, prate};
        mul_b = {{(MUL_B_W-24){1'b0}}, rate_gain};
      end
      S_PT: begin
        mul_a = yf;
        mul_b = {{(MUL_B_W-16){1'b0}}, prop_gain};
      end
      S_YR_M: begin
        mul_a = {{(MUL_A_W-ANGLE_BITS){yrate[ANGLE_BITS-1]}}, yrate};
        mul_b = {{(MUL_B_W-24){1'b0}}, rate_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  gpdt_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign gp_sum = $signed({2'b00, ppos}) + $signed({step_p[STEP_W-1], step_p});
  assign goal_p = gp_sum[POS_W+1] ? '0 : (gp_sum[POS_W] ? '1 : gp_sum[POS_W-1:0]);
  assign goal_y = ypos + step_y[POS_W-1:0];

  assign load_out = (state == S_DONE) && (!out_valid || m_axis_tready);

  assign out_mag_p = out_step_p[STEP_W-1] ? -out_step_p : out_step_p;
  assign out_mag_y = out_step_y[STEP_W-1] ? -out_step_y : out_step_y;
  assign steps_in_limit = (out_mag_p <= {1'b0, lim_p_c}) && (out_mag_y <= {1'b0, lim_y_c});

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      calibrated       <= 1'b0;
      lpf_alpha        <= ALPHA_W'(15669);
      hpf_alpha        <= ALPHA_W'(612);
      prop_gain        <= 16'd256;
      rate_gain        <= '0;
      pitch_step_limit <= LIM_W'(200);
      yaw_step_limit   <= LIM_W'(200);
      slow_yaw_follow  <= 1'b0;
      ref_p            <= '0;
      ref_y            <= '0;
      prev_p           <= '0;
      prev_y           <= '0;
      pf               <= '0;
      yf               <= '0;
      trk              <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index_t'(cfg_index))
          CFG_LPF_ALPHA:        lpf_alpha        <= cfg_data[ALPHA_W-1:0];
          CFG_HPF_ALPHA:        hpf_alpha        <= cfg_data[ALPHA_W-1:0];
          CFG_PROP_GAIN:        prop_gain        <= cfg_data[15:0];
          CFG_RATE_GAIN:        rate_gain        <= cfg_data[23:0];
          CFG_PITCH_STEP_LIMIT: pitch_step_limit <= cfg_data[LIM_W-1:0];
          CFG_YAW_STEP_LIMIT:   yaw_step_limit   <= cfg_data[LIM_W-1:0];
          CFG_SLOW_YAW_FOLLOW:  slow_yaw_follow  <= cfg_data[0];
          default: ;
        endcase
      end

      if (m_axis_tready && !load_out) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            pa   <= s_axis_tdata[15:0];
            ya   <= s_axis_tdata[31:16];
            ppos <= s_axis_tdata[43:32];
            ypos <= s_axis_tdata[55:44];
            if (!calibrated) begin
              ref_p      <= s_axis_tdata[15:0];
              prev_p     <= s_axis_tdata[15:0];
              ref_y      <= s_axis_tdata[31:16];
              prev_y     <= s_axis_tdata[31:16];
              pf         <= '0;
              yf         <= '0;
              calibrated <= 1'b1;
              step_p     <= '0;
              step_y     <= '0;
              cal        <= 1'b1;
              state      <= S_DONE;
            end else begin
              cal   <= 1'b0;
              state <= slow_yaw_follow ? S_TRK_M : S_PF_M;
            end
          end
        end
        S_TRK_M: state <= S_TRK_W;
        S_TRK_W: begin
          trk   <= trk + rnd16(prod);
          state <= S_PF_M;
        end
        S_PF_M: state <= S_PF_W;
        S_PF_W: begin
          pf    <= pf + rnd16(prod);
          state <= S_YF_M;
        end
        S_YF_M: state <= S_YF_W;
        S_YF_W: begin
          yf    <= yf + rnd16(prod);
          state <= S_PP_M;
        end
        S_PP_M: state <= S_PR_M;
        S_PR_M: begin
          acc   <= prod[SUM_W-1:0];
          state <= S_PR_W;
        end
        S_PR_W: begin
          acc   <= acc + $signed({prod[SUM_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}});
          state <= S_PT;
        end
        S_PT: begin
          step_p <= tick_step(acc, lim_p_c);
          state  <= S_YR_M;
        end
        S_YR_M: begin
          acc   <= prod[SUM_W-1:0];
          state <= S_YR_W;
        end
        S_YR_W: begin
          acc   <= acc + $signed({prod[SUM_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}});
          state <= S_YT;
        end
        S_YT: begin
          step_y <= tick_step(acc, lim_y_c);
          prev_p <= pa;
          prev_y <= ya;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            out_goal_p <= goal_p;
            out_goal_y <= goal_y;
            out_step_p <= step_p;
            out_step_y <= step_y;
            out_cal    <= cal;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_cal_zero_step, m_axis_tvalid && m_axis_tuser, m_axis_tdata[49:24] == '0)
  `ASSERT_IMPLIES(a_step_in_limit, m_axis_tvalid && !m_axis_tuser, steps_in_limit)
  `ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

`default_nettype wire
